/* design/assert_macros.svh */
// assertion helpers shared by the rtl modules of the drag-resize block
// expects clk_i and an active-low rst_ni in the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/wedr_pkg.sv */
// shared types, codes and microcode table of the drag-resize block
// no dependencies
`default_nettype none

package wedr_pkg;

  // field widths
  localparam int POS_W  = 16;
  localparam int SIZE_W = 15;
  localparam int OUT_W  = 18;
  localparam int CNT_W  = $clog2(SIZE_W + 1);
  localparam int STEP_W = 3;

  // default minimum sizes when a begin word asks for zero
  localparam logic [SIZE_W-1:0] DEFAULT_MIN_WIDTH  = SIZE_W'(100);
  localparam logic [SIZE_W-1:0] DEFAULT_MIN_HEIGHT = SIZE_W'(100);

  // register reset values
  localparam logic [SIZE_W-1:0] CEIL_RESET = SIZE_W'(8192);
  localparam logic [SIZE_W-1:0] SNAP_RESET = SIZE_W'(1);

  // register indexes (word address bits 3:2)
  localparam logic [1:0] REG_WIDTH_CEIL  = 2'd0;
  localparam logic [1:0] REG_HEIGHT_CEIL = 2'd1;
  localparam logic [1:0] REG_SNAP_STEP   = 2'd2;

  // item modes
  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;
  localparam logic [1:0] MODE_HOLD  = 2'd3;

  // grabbed zones
  localparam logic [3:0] EDGE_E    = 4'd0;
  localparam logic [3:0] EDGE_W    = 4'd1;
  localparam logic [3:0] EDGE_S    = 4'd2;
  localparam logic [3:0] EDGE_N    = 4'd3;
  localparam logic [3:0] EDGE_SE   = 4'd4;
  localparam logic [3:0] EDGE_SW   = 4'd5;
  localparam logic [3:0] EDGE_NE   = 4'd6;
  localparam logic [3:0] EDGE_NW   = 4'd7;
  localparam logic [3:0] EDGE_NONE = 4'd8;

  // microcode step labels
  localparam logic [STEP_W-1:0] ST_WAIT      = 3'd0;
  localparam logic [STEP_W-1:0] ST_LATCH     = 3'd1;
  localparam logic [STEP_W-1:0] ST_RAW       = 3'd2;
  localparam logic [STEP_W-1:0] ST_CLAMP     = 3'd3;
  localparam logic [STEP_W-1:0] ST_SNAP      = 3'd4;
  localparam logic [STEP_W-1:0] ST_SNAP_WAIT = 3'd5;
  localparam logic [STEP_W-1:0] ST_PUBLISH   = 3'd6;
  localparam logic [STEP_W-1:0] ST_RETURN    = 3'd7;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TAKE,
    OP_LATCH,
    OP_RAW,
    OP_CLAMP,
    OP_SNAP_GO,
    OP_PUBLISH
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_NO_GEOM,
    C_SNAP_BUSY,
    C_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic no_item;
    logic no_geom;
    logic snap_busy;
    logic out_blocked;
  } status_t;

  // one input word
  typedef struct packed {
    logic [1:0]               mode;
    logic [3:0]               edge_zone;
    logic signed [POS_W-1:0]  pointer_x;
    logic signed [POS_W-1:0]  pointer_y;
    logic signed [POS_W-1:0]  win_left;
    logic signed [POS_W-1:0]  win_top;
    logic [SIZE_W-1:0]        win_width;
    logic [SIZE_W-1:0]        win_height;
    logic [SIZE_W-1:0]        req_min_width;
    logic [SIZE_W-1:0]        req_min_height;
  } item_t;

  typedef struct packed {
    logic east;
    logic west;
    logic south;
    logic north;
  } sides_t;

  // which sides follow the pointer for a grabbed zone
  function automatic sides_t edge_sides(input logic [3:0] zone);
    sides_t s;
    s = '0;
    unique case (zone)
      EDGE_E:  s.east = 1'b1;
      EDGE_W:  s.west = 1'b1;
      EDGE_S:  s.south = 1'b1;
      EDGE_N:  s.north = 1'b1;
      EDGE_SE: begin
        s.south = 1'b1;
        s.east  = 1'b1;
      end
      EDGE_SW: begin
        s.south = 1'b1;
        s.west  = 1'b1;
      end
      EDGE_NE: begin
        s.north = 1'b1;
        s.east  = 1'b1;
      end
      EDGE_NW: begin
        s.north = 1'b1;
        s.west  = 1'b1;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  // control program: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_WAIT};
    unique case (step)
      ST_WAIT:      w = '{op: OP_TAKE,    cond: C_NO_ITEM,     target: ST_WAIT};
      ST_LATCH:     w = '{op: OP_LATCH,   cond: C_NEVER,       target: ST_WAIT};
      ST_RAW:       w = '{op: OP_RAW,     cond: C_NO_GEOM,     target: ST_PUBLISH};
      ST_CLAMP:     w = '{op: OP_CLAMP,   cond: C_NEVER,       target: ST_WAIT};
      ST_SNAP:      w = '{op: OP_SNAP_GO, cond: C_NEVER,       target: ST_WAIT};
      ST_SNAP_WAIT: w = '{op: OP_NOP,     cond: C_SNAP_BUSY,   target: ST_SNAP_WAIT};
      ST_PUBLISH:   w = '{op: OP_PUBLISH, cond: C_OUT_BLOCKED, target: ST_PUBLISH};
      ST_RETURN:    w = '{op: OP_NOP,     cond: C_ALWAYS,      target: ST_WAIT};
      default:      w = '{op: OP_NOP,     cond: C_ALWAYS,      target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/window_edge_drag_resize_top.sv */
// top level of the drag-resize block: register port, word capture, output register
// depends on wedr_pkg, wedr_seq, wedr_geom, wedr_snap and assert_macros.svh
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_stall_o     mode_i .. req_min_height_i
//   out       output     out_valid_o / out_stall_i   new_x_o .. in_drag_o
//   config    input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// a begin word, or a move during a drag, goes through latch, offset, clamp and grid snap
// before publish; the grid snap is a two-lane remainder pass, one bit a cycle
// end, hold and idle moves skip the clamp and that pass and go straight to publish
// reset clears the drag, the ceilings to 8192 and the snap step to 1
// a stalled result sits in the output register; the next word is still taken
`default_nettype none
`include "assert_macros.svh"

module window_edge_drag_resize_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [3:0]                          edge_zone_i,
  input  logic signed [wedr_pkg::POS_W-1:0]   pointer_x_i,
  input  logic signed [wedr_pkg::POS_W-1:0]   pointer_y_i,
  input  logic signed [wedr_pkg::POS_W-1:0]   win_left_i,
  input  logic signed [wedr_pkg::POS_W-1:0]   win_top_i,
  input  logic [wedr_pkg::SIZE_W-1:0]         win_width_i,
  input  logic [wedr_pkg::SIZE_W-1:0]         win_height_i,
  input  logic [wedr_pkg::SIZE_W-1:0]         req_min_width_i,
  input  logic [wedr_pkg::SIZE_W-1:0]         req_min_height_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wedr_pkg::OUT_W-1:0]   new_x_o,
  output logic signed [wedr_pkg::OUT_W-1:0]   new_y_o,
  output logic [wedr_pkg::SIZE_W-1:0]         new_width_o,
  output logic [wedr_pkg::SIZE_W-1:0]         new_height_o,
  output logic                                in_drag_o
);
  import wedr_pkg::*;

  logic [SIZE_W-1:0]       wceil_q, hceil_q, snap_q;
  logic                    cfg_wr;
  op_e                     op;
  status_t                 status;
  item_t                   item_q;
  logic                    take, publish, geom_item;
  logic                    active;
  logic signed [OUT_W-1:0] gx, gy;
  logic [SIZE_W-1:0]       gw, gh, sw, sh;
  logic                    snap_busy;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q;
  logic [SIZE_W-1:0]       out_w_q, out_h_q;
  logic                    out_drag_q;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wceil_q <= CEIL_RESET;
      hceil_q <= CEIL_RESET;
      snap_q  <= SNAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH_CEIL:  wceil_q <= pwdata[SIZE_W-1:0];
        REG_HEIGHT_CEIL: hceil_q <= pwdata[SIZE_W-1:0];
        REG_SNAP_STEP:   snap_q  <= pwdata[SIZE_W-1:0];
        default:         ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH_CEIL:  prdata = {{(32-SIZE_W){1'b0}}, wceil_q};
      REG_HEIGHT_CEIL: prdata = {{(32-SIZE_W){1'b0}}, hceil_q};
      REG_SNAP_STEP:   prdata = {{(32-SIZE_W){1'b0}}, snap_q};
      default:         prdata = '0;
    endcase
  end

  // word capture in the wait step
  assign in_stall_o = (op != OP_TAKE);
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.mode           <= mode_i;
      item_q.edge_zone      <= edge_zone_i;
      item_q.pointer_x      <= pointer_x_i;
      item_q.pointer_y      <= pointer_y_i;
      item_q.win_left       <= win_left_i;
      item_q.win_top        <= win_top_i;
      item_q.win_width      <= win_width_i;
      item_q.win_height     <= win_height_i;
      item_q.req_min_width  <= req_min_width_i;
      item_q.req_min_height <= req_min_height_i;
    end
  end

  // geometry only for a begin, or a move while dragging
  assign geom_item = (item_q.mode == MODE_BEGIN) || (item_q.mode == MODE_MOVE && active);

  assign status.no_item     = !in_valid_i;
  assign status.no_geom     = !geom_item;
  assign status.snap_busy   = snap_busy;
  assign status.out_blocked = out_valid_q && out_stall_i;

  assign publish = (op == OP_PUBLISH) && !status.out_blocked;

  wedr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  wedr_geom u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .item_i        (item_q),
    .width_ceil_i  (wceil_q),
    .height_ceil_i (hceil_q),
    .active_o      (active),
    .x_o           (gx),
    .y_o           (gy),
    .width_o       (gw),
    .height_o      (gh)
  );

  wedr_snap u_snap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (op == OP_SNAP_GO),
    .step_i   (snap_q),
    .width_i  (gw),
    .height_i (gh),
    .busy_o   (snap_busy),
    .width_o  (sw),
    .height_o (sh)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) begin
      if (geom_item) begin
        out_x_q    <= gx;
        out_y_q    <= gy;
        out_w_q    <= sw;
        out_h_q    <= sh;
        out_drag_q <= 1'b1;
      end else begin
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_w_q    <= '0;
        out_h_q    <= '0;
        out_drag_q <= (item_q.mode == MODE_HOLD) && active;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_x_o      = out_x_q;
  assign new_y_o      = out_y_q;
  assign new_width_o  = out_w_q;
  assign new_height_o = out_h_q;
  assign in_drag_o    = out_drag_q;

  `ASSERT_IMP(a_idle_zero, out_valid_q && !out_drag_q,
              out_x_q == '0 && out_y_q == '0 && out_w_q == '0 && out_h_q == '0,
              "geometry not zero outside a drag")

endmodule

`default_nettype wire

/* design/wedr_snap.sv */
// two-lane remainder unit that snaps width and height down to the grid step
// depends on wedr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wedr_snap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wedr_pkg::SIZE_W-1:0]   step_i,
  input  logic [wedr_pkg::SIZE_W-1:0]   width_i,
  input  logic [wedr_pkg::SIZE_W-1:0]   height_i,
  output logic                          busy_o,
  output logic [wedr_pkg::SIZE_W-1:0]   width_o,
  output logic [wedr_pkg::SIZE_W-1:0]   height_o
);
  import wedr_pkg::*;

  localparam logic [CNT_W-1:0] SNAP_STEPS = CNT_W'(SIZE_W);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SIZE_W-1:0]   step_q;
  logic                bypass_q;
  logic [SIZE_W-1:0]   opnd [2];
  logic [SIZE_W-1:0]   dvd_q [2];
  logic [SIZE_W-1:0]   orig_q [2];
  logic [SIZE_W:0]     rem_q [2];
  logic [SIZE_W-1:0]   res [2];

  assign opnd[0] = width_i;
  assign opnd[1] = height_i;

  // step counter, one dividend bit per cycle
  always_comb begin
    busy_d  = busy_q;
    count_d = count_q;
    if (start_i) begin
      busy_d  = 1'b1;
      count_d = SNAP_STEPS;
    end else if (busy_q) begin
      count_d = count_q - CNT_W'(1);
      busy_d  = (count_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= busy_d;
      count_q <= count_d;
    end
  end

  // step is held for the whole pass; 0 or 1 leaves sizes as they are
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      step_q   <= step_i;
      bypass_q <= (step_i <= SIZE_W'(1));
    end
  end

  // restoring remainder, one lane each for width and height
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [SIZE_W:0] rem_sh;
    logic [SIZE_W:0] rem_nx;

    always_comb begin
      rem_sh = {rem_q[l][SIZE_W-1:0], dvd_q[l][SIZE_W-1]};
      rem_nx = (rem_sh >= {1'b0, step_q}) ? (rem_sh - {1'b0, step_q}) : rem_sh;
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q[l]  <= '0;
        dvd_q[l]  <= opnd[l];
        orig_q[l] <= opnd[l];
      end else if (busy_q) begin
        rem_q[l]  <= rem_nx;
        dvd_q[l]  <= {dvd_q[l][SIZE_W-2:0], 1'b0};
      end
    end

    // remainder stays below the step, so it fits the size width
    assign res[l] = bypass_q ? orig_q[l] : (orig_q[l] - rem_q[l][SIZE_W-1:0]);
  end

  assign busy_o   = busy_q;
  assign width_o  = res[0];
  assign height_o = res[1];

  `ASSERT_IMP(a_busy_count, busy_q, count_q != '0, "snap busy with empty step count")
  `ASSERT_IMP(a_snap_down, $fell(busy_q), width_o <= orig_q[0] && height_o <= orig_q[1],
              "snapped size above its input")

endmodule

`default_nettype wire

/* design/wedr_geom.sv */
// drag state and offset/clamp datapath of the drag-resize block
// depends on wedr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wedr_geom (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wedr_pkg::op_e                     op_i,
  input  wedr_pkg::item_t                   item_i,
  input  logic [wedr_pkg::SIZE_W-1:0]       width_ceil_i,
  input  logic [wedr_pkg::SIZE_W-1:0]       height_ceil_i,
  output logic                              active_o,
  output logic signed [wedr_pkg::OUT_W-1:0] x_o,
  output logic signed [wedr_pkg::OUT_W-1:0] y_o,
  output logic [wedr_pkg::SIZE_W-1:0]       width_o,
  output logic [wedr_pkg::SIZE_W-1:0]       height_o
);
  import wedr_pkg::*;

  logic                      active_q;
  logic [3:0]                edge_q;
  logic signed [POS_W-1:0]   apx_q, apy_q, ax_q, ay_q;
  logic [SIZE_W-1:0]         aw_q, ah_q, fw_q, fh_q;
  logic signed [OUT_W-1:0]   raw_w_q, raw_h_q, raw_x_q, raw_y_q;
  logic signed [OUT_W-1:0]   x_q, y_q;
  logic [SIZE_W-1:0]         w_q, h_q;
  sides_t                    sd;

  // drag flag and grabbed zone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      edge_q   <= EDGE_NONE;
    end else if (op_i == OP_LATCH) begin
      if (item_i.mode == MODE_BEGIN) begin
        active_q <= 1'b1;
        edge_q   <= item_i.edge_zone;
      end else if (item_i.mode == MODE_END) begin
        active_q <= 1'b0;
      end
    end
  end

  // anchors and floors on a begin word
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LATCH && item_i.mode == MODE_BEGIN) begin
      apx_q <= item_i.pointer_x;
      apy_q <= item_i.pointer_y;
      ax_q  <= item_i.win_left;
      ay_q  <= item_i.win_top;
      aw_q  <= item_i.win_width;
      ah_q  <= item_i.win_height;
      fw_q  <= (item_i.req_min_width != '0) ? item_i.req_min_width : DEFAULT_MIN_WIDTH;
      fh_q  <= (item_i.req_min_height != '0) ? item_i.req_min_height : DEFAULT_MIN_HEIGHT;
    end
  end

  assign sd = edge_sides(edge_q);

  // offset the grabbed sides by the pointer delta
  logic signed [POS_W:0]   dx, dy;
  logic signed [OUT_W-1:0] dx_e, dy_e, aw_e, ah_e, ax_e, ay_e;

  always_comb begin
    dx   = {item_i.pointer_x[POS_W-1], item_i.pointer_x} - {apx_q[POS_W-1], apx_q};
    dy   = {item_i.pointer_y[POS_W-1], item_i.pointer_y} - {apy_q[POS_W-1], apy_q};
    dx_e = {dx[POS_W], dx};
    dy_e = {dy[POS_W], dy};
    aw_e = {3'b000, aw_q};
    ah_e = {3'b000, ah_q};
    ax_e = {{(OUT_W-POS_W){ax_q[POS_W-1]}}, ax_q};
    ay_e = {{(OUT_W-POS_W){ay_q[POS_W-1]}}, ay_q};
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_RAW) begin
      raw_w_q <= sd.east ? (aw_e + dx_e) : (sd.west ? (aw_e - dx_e) : aw_e);
      raw_x_q <= sd.west ? (ax_e + dx_e) : ax_e;
      raw_h_q <= sd.south ? (ah_e + dy_e) : (sd.north ? (ah_e - dy_e) : ah_e);
      raw_y_q <= sd.north ? (ay_e + dy_e) : ay_e;
    end
  end

  // raise to the floor, keep the opposite side on west/north, then cap
  logic signed [OUT_W-1:0] fw_e, fh_e, cw_e, ch_e, lo_w, lo_h, cx, cy;

  always_comb begin
    fw_e = {3'b000, fw_q};
    fh_e = {3'b000, fh_q};
    cw_e = {3'b000, width_ceil_i};
    ch_e = {3'b000, height_ceil_i};
    lo_w = raw_w_q;
    cx   = raw_x_q;
    if (raw_w_q < fw_e) begin
      lo_w = fw_e;
      if (sd.west) begin
        cx = ax_e + aw_e - fw_e;
      end
    end
    lo_h = raw_h_q;
    cy   = raw_y_q;
    if (raw_h_q < fh_e) begin
      lo_h = fh_e;
      if (sd.north) begin
        cy = ay_e + ah_e - fh_e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_CLAMP) begin
      x_q <= cx;
      y_q <= cy;
      w_q <= (lo_w > cw_e) ? width_ceil_i : lo_w[SIZE_W-1:0];
      h_q <= (lo_h > ch_e) ? height_ceil_i : lo_h[SIZE_W-1:0];
    end
  end

  assign active_o = active_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign width_o  = w_q;
  assign height_o = h_q;

  `ASSERT_NXT(a_clamp_ceil, op_i == OP_CLAMP,
              w_q <= $past(width_ceil_i) && h_q <= $past(height_ceil_i),
              "clamped size above its ceiling")

endmodule

`default_nettype wire

/* design/wedr_seq.sv */
// microcode sequencer: step counter, control table and conditional jumps
// depends on wedr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wedr_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wedr_pkg::status_t status_i,
  output wedr_pkg::op_e     op_o
);
  import wedr_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uw;
  logic              jump;

  assign uw = ucode_rom(step_q);

  // jump condition select
  always_comb begin
    unique case (uw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_ITEM:     jump = status_i.no_item;
      C_NO_GEOM:     jump = status_i.no_geom;
      C_SNAP_BUSY:   jump = status_i.snap_busy;
      C_OUT_BLOCKED: jump = status_i.out_blocked;
      default:       jump = 1'b1;
    endcase
    step_d = jump ? uw.target : (step_q + STEP_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign op_o = uw.op;

  `ASSERT_NXT(a_take_to_latch, step_q == ST_WAIT && !status_i.no_item, step_q == ST_LATCH,
              "accepted word did not reach the latch step")

endmodule

`default_nettype wire
